### rtl/crf_pkg.sv
// Shared types and constants for the clipped rectangle fill engine.
// No dependencies; imported by every module of the block.
package crf_pkg;

  localparam int CMD_W   = 3;
  localparam int COORD_W = 12;
  localparam int PIX_W   = 32;
  localparam int FRAME_W = 8;
  localparam int EXT_W   = 13;
  localparam int END_W   = 14;

  localparam logic [FRAME_W-1:0] FRAME_RESET = 8'd128;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR   = 3'd0,
    CMD_FILL    = 3'd1,
    CMD_OUTLINE = 3'd2,
    CMD_WRITE   = 3'd3,
    CMD_READ    = 3'd4
  } cmd_t;

  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PREP,
    ST_DRAW,
    ST_RDWAIT
  } state_t;

endpackage

### rtl/crf_store.sv
// Pixel store: single-port synchronous RAM, registered read data.
// Uses crf_pkg for the pixel width.
module crf_store import crf_pkg::*; #(
  parameter int DEPTH = 16384,
  parameter int AW    = 14
) (
  input  logic             clk,
  input  logic             we,
  input  logic             re,
  input  logic [AW-1:0]    addr,
  input  logic [PIX_W-1:0] wdata,
  output logic [PIX_W-1:0] rdata
);

  logic [PIX_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

### rtl/crf_seq.sv
// Command sequencer: clips rectangles and walks them one pixel a cycle.
// Uses crf_pkg; drives the port of crf_store.
module crf_seq import crf_pkg::*; #(
  parameter int MAX_WIDTH = 128,
  parameter int AW        = 14
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [CMD_W-1:0]   command,
  input  logic [COORD_W-1:0] pos_x,
  input  logic [COORD_W-1:0] pos_y,
  input  logic [COORD_W-1:0] rect_w,
  input  logic [COORD_W-1:0] rect_h,
  input  logic [PIX_W-1:0]   pixel_value,
  input  logic [FRAME_W-1:0] active_w,
  input  logic [FRAME_W-1:0] active_h,
  output logic               mem_we,
  output logic               mem_re,
  output logic [AW-1:0]      mem_addr,
  output logic [PIX_W-1:0]   mem_wdata,
  input  logic [PIX_W-1:0]   mem_rdata,
  output logic               done,
  output logic [PIX_W-1:0]   read_value
);

  state_t             state, state_next;
  logic [CMD_W-1:0]   cmd_l;
  logic [COORD_W-1:0] x_l, y_l, w_l, h_l;
  logic [PIX_W-1:0]   colour;
  logic [1:0]         part, part_next;
  logic [FRAME_W-1:0] cur_x, cur_x_next, cur_y, cur_y_next;
  logic [FRAME_W-1:0] x_start, x_start_next, x_end, x_end_next, y_end, y_end_next;
  logic               done_next;
  logic [PIX_W-1:0]   read_value_next;

  logic [EXT_W-1:0]   x0, y0, rw, rh;
  logic [END_W-1:0]   xs, ys;
  logic               part_ok, last_part, finish;
  logic [COORD_W-1:0] addr_x, addr_y;

  assign busy      = (state != ST_IDLE);
  assign mem_wdata = colour;
  assign addr_x    = (state == ST_PREP) ? x_l : COORD_W'(cur_x);
  assign addr_y    = (state == ST_PREP) ? y_l : COORD_W'(cur_y);
  assign mem_addr  = AW'(32'(addr_y) * MAX_WIDTH + 32'(addr_x));

  // rectangle of the current part
  always_comb begin
    x0 = EXT_W'(x_l);
    y0 = EXT_W'(y_l);
    rw = EXT_W'(w_l);
    rh = EXT_W'(h_l);
    case (cmd_l)
      CMD_CLEAR: begin
        x0 = '0;
        y0 = '0;
        rw = EXT_W'(active_w);
        rh = EXT_W'(active_h);
      end
      CMD_OUTLINE: begin
        case (part)
          2'd0: rh = EXT_W'(1);
          2'd1: begin
            y0 = EXT_W'(y_l) + EXT_W'(h_l) - EXT_W'(1);
            rh = EXT_W'(1);
          end
          2'd2: rw = EXT_W'(1);
          default: begin
            x0 = EXT_W'(x_l) + EXT_W'(w_l) - EXT_W'(1);
            rw = EXT_W'(1);
          end
        endcase
      end
      CMD_WRITE: begin
        rw = EXT_W'(1);
        rh = EXT_W'(1);
      end
      default: ;
    endcase
    xs        = END_W'(x0) + END_W'(rw);
    ys        = END_W'(y0) + END_W'(rh);
    part_ok   = (x0 < EXT_W'(active_w)) && (y0 < EXT_W'(active_h)) &&
                (rw != '0) && (rh != '0);
    last_part = (cmd_l != CMD_OUTLINE) || (part == 2'd3);
  end

  always_comb begin
    state_next      = state;
    part_next       = part;
    cur_x_next      = cur_x;
    cur_y_next      = cur_y;
    x_start_next    = x_start;
    x_end_next      = x_end;
    y_end_next      = y_end;
    read_value_next = '0;
    finish          = 1'b0;
    mem_we          = 1'b0;
    mem_re          = 1'b0;
    case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = ST_PREP;
          part_next  = '0;
        end
      end
      ST_PREP: begin
        case (cmd_l)
          CMD_READ: begin
            if ((x_l < COORD_W'(active_w)) && (y_l < COORD_W'(active_h))) begin
              mem_re     = 1'b1;
              state_next = ST_RDWAIT;
            end else begin
              finish = 1'b1;
            end
          end
          CMD_CLEAR, CMD_FILL, CMD_OUTLINE, CMD_WRITE: begin
            if (cmd_l == CMD_OUTLINE && (w_l == '0 || h_l == '0)) begin
              finish = 1'b1;
            end else if (part_ok) begin
              cur_x_next   = FRAME_W'(x0);
              cur_y_next   = FRAME_W'(y0);
              x_start_next = FRAME_W'(x0);
              x_end_next   = (xs > END_W'(active_w)) ? active_w : FRAME_W'(xs);
              y_end_next   = (ys > END_W'(active_h)) ? active_h : FRAME_W'(ys);
              state_next   = ST_DRAW;
            end else if (last_part) begin
              finish = 1'b1;
            end else begin
              part_next = part + 2'd1;
            end
          end
          default: finish = 1'b1;
        endcase
      end
      ST_DRAW: begin
        mem_we = 1'b1;
        if ({1'b0, cur_x} + 9'd1 == {1'b0, x_end}) begin
          cur_x_next = x_start;
          if ({1'b0, cur_y} + 9'd1 == {1'b0, y_end}) begin
            if (last_part) begin
              finish = 1'b1;
            end else begin
              part_next  = part + 2'd1;
              state_next = ST_PREP;
            end
          end else begin
            cur_y_next = cur_y + FRAME_W'(1);
          end
        end else begin
          cur_x_next = cur_x + FRAME_W'(1);
        end
      end
      ST_RDWAIT: begin
        read_value_next = mem_rdata;
        finish          = 1'b1;
      end
      default: state_next = ST_IDLE;
    endcase
    if (finish) begin
      state_next = ST_IDLE;
    end
    done_next = finish;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      done       <= 1'b0;
      read_value <= '0;
    end else begin
      state      <= state_next;
      done       <= done_next;
      read_value <= read_value_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && start) begin
      cmd_l  <= command;
      x_l    <= pos_x;
      y_l    <= pos_y;
      w_l    <= rect_w;
      h_l    <= rect_h;
      colour <= pixel_value;
    end
    part    <= part_next;
    cur_x   <= cur_x_next;
    cur_y   <= cur_y_next;
    x_start <= x_start_next;
    x_end   <= x_end_next;
    y_end   <= y_end_next;
  end

endmodule

### rtl/clipped_rect_fill_engine_unit.sv
// Clipped rectangle fill engine: top level with frame size registers.
// Uses crf_pkg; instantiates crf_seq and crf_store.
//
// Usage:
//   Command channel: an item is taken when start is high and busy is low.
//   Every item gives exactly one result: done is high for one cycle with
//   read_value, which is the pixel for a read inside the frame and 0 for
//   everything else. The receiver cannot stall; results are never held.
//   Config channel: cfg_ready is always high; cfg_index 0 is frame width,
//   1 is frame height. Write only while busy is low and no result is due.
// Sequence from acceptance to done, one item at a time: PREP, then for
//   a read RDWAIT, for a write, fill or clear DRAW over each clipped pixel.
//   Outline: PREP per edge examined, DRAW over each clipped edge. An item
//   with nothing inside the frame (or an outline with w or h zero) ends in PREP.
//   The single-port pixel RAM is written one pixel per cycle, which sets
//   the fill rate.
//   busy falls in the cycle done is shown, so the next command may be
//   taken alongside the result.
// Reset: frame width and height return to 128, sequencer goes idle. The
//   pixel store is not cleared; issue a clear command before reading.
module clipped_rect_fill_engine_unit import crf_pkg::*; #(
  parameter int MAX_WIDTH  = 128,
  parameter int MAX_HEIGHT = 128
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [CMD_W-1:0]   command,
  input  logic [COORD_W-1:0] pos_x,
  input  logic [COORD_W-1:0] pos_y,
  input  logic [COORD_W-1:0] rect_w,
  input  logic [COORD_W-1:0] rect_h,
  input  logic [PIX_W-1:0]   pixel_value,
  output logic               done,
  output logic [PIX_W-1:0]   read_value,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [FRAME_W-1:0] cfg_data
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [FRAME_W-1:0] frame_width, frame_height;
  logic [FRAME_W-1:0] active_w, active_h;
  logic               mem_we, mem_re;
  logic [AW-1:0]      mem_addr;
  logic [PIX_W-1:0]   mem_wdata, mem_rdata;

  assign cfg_ready = 1'b1;
  assign active_w  = (32'(frame_width) > MAX_WIDTH) ? FRAME_W'(MAX_WIDTH) : frame_width;
  assign active_h  = (32'(frame_height) > MAX_HEIGHT) ? FRAME_W'(MAX_HEIGHT) : frame_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FRAME_RESET;
      frame_height <= FRAME_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_FRAME_WIDTH:  frame_width  <= cfg_data;
        REG_FRAME_HEIGHT: frame_height <= cfg_data;
        default: ;
      endcase
    end
  end

  crf_seq #(
    .MAX_WIDTH (MAX_WIDTH),
    .AW        (AW)
  ) u_seq (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .command     (command),
    .pos_x       (pos_x),
    .pos_y       (pos_y),
    .rect_w      (rect_w),
    .rect_h      (rect_h),
    .pixel_value (pixel_value),
    .active_w    (active_w),
    .active_h    (active_h),
    .mem_we      (mem_we),
    .mem_re      (mem_re),
    .mem_addr    (mem_addr),
    .mem_wdata   (mem_wdata),
    .mem_rdata   (mem_rdata),
    .done        (done),
    .read_value  (read_value)
  );

  crf_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .re    (mem_re),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

endmodule

### rtl/crf_checker.sv
// Port-level checks on the fill engine's command and result channels.
// Uses crf_pkg; bound to clipped_rect_fill_engine_unit below.
module crf_checker import crf_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic               done,
  input logic [PIX_W-1:0]   read_value
);

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(done) |-> $past(busy))
    else $error("result strobe without a transaction in flight");

  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe longer than one cycle");

  a_value_quiet: assert property (@(posedge clk) disable iff (rst)
    (read_value != '0) |-> done)
    else $error("read_value nonzero outside a result");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> (!busy && !done))
    else $error("not idle after reset");

endmodule

bind clipped_rect_fill_engine_unit crf_checker u_crf_checker (
  .clk        (clk),
  .rst        (rst),
  .start      (start),
  .busy       (busy),
  .done       (done),
  .read_value (read_value)
);
